>>> hdl/pwmc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_pkg
// Shared widths and constants of the PWM period, duty and prescaler calculator.
// ----------------------------------------------------------------------------
package pwmc_pkg;

    localparam int DUTY_W     = 16;
    localparam int FREQ_IN_W  = 20;
    localparam int RES_W      = 4;
    localparam int CNT_OUT_W  = 15;
    localparam int IDX_W      = 3;

    // Clamped frequency fits 19 bits; the period in microseconds fits 18 bits.
    localparam int FREQ_W     = 19;
    localparam int PERIOD_W   = 18;
    localparam int DIV_W      = 20;
    localparam int TICK_SHIFT = 4;
    localparam int TICK_W     = PERIOD_W + TICK_SHIFT;

    localparam logic [FREQ_IN_W-1:0] FREQ_MAX      = 20'd500000;
    localparam logic [FREQ_IN_W-1:0] FREQ_MIN      = 20'd4;
    localparam logic [DIV_W-1:0]     US_PER_SECOND = 20'd1000000;

    typedef logic [FREQ_W-1:0]   freq_t;
    typedef logic [PERIOD_W-1:0] period_t;

endpackage

>>> hdl/pwm_period_duty_prescaler_calc.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_prescaler_calc
// Computes PWM counter top, inverted compare value and prescaler index from
// a duty value, a frequency and a resolution.
// ----------------------------------------------------------------------------
// Pipeline: 3 front stages, 20 divider stages with one quotient bit each and 3
// back-end stages. Throughput: one item per cycle while out_ready holds; each
// stage moves whenever its successor has room, so bubbles collapse and a
// stalled output holds without loss.
// Reset: rst_n clears all stage valid bits; the pipeline comes up empty.
module pwm_period_duty_prescaler_calc
    import pwmc_pkg::*;
#(
    parameter int COUNTER_BITS    = 15,
    parameter int PRESCALER_STEPS = 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [DUTY_W-1:0]    duty_value,
    input  logic [FREQ_IN_W-1:0] freq_hz,
    input  logic [RES_W-1:0]     res_bits,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [CNT_OUT_W-1:0] compare_count,
    output logic [CNT_OUT_W-1:0] top_count,
    output logic [IDX_W-1:0]     clock_index
);

    logic                    f_valid, f_ready;
    logic [COUNTER_BITS-1:0] f_scaled;
    freq_t                   f_freq;
    logic                    d_valid, d_ready;
    period_t                 d_period;
    logic [COUNTER_BITS-1:0] d_scaled;

    pwmc_front #(
        .COUNTER_BITS (COUNTER_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .duty_value (duty_value),
        .freq_hz    (freq_hz),
        .res_bits   (res_bits),
        .out_valid  (f_valid),
        .out_ready  (f_ready),
        .out_scaled (f_scaled),
        .out_freq   (f_freq)
    );

    pwmc_div #(
        .SIDE_W (COUNTER_BITS)
    ) u_div (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (f_valid),
        .in_ready   (f_ready),
        .in_divisor (f_freq),
        .in_side    (f_scaled),
        .out_valid  (d_valid),
        .out_ready  (d_ready),
        .out_quot   (d_period),
        .out_side   (d_scaled)
    );

    pwmc_back #(
        .COUNTER_BITS    (COUNTER_BITS),
        .PRESCALER_STEPS (PRESCALER_STEPS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (d_valid),
        .in_ready      (d_ready),
        .in_scaled     (d_scaled),
        .in_period     (d_period),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .compare_count (compare_count),
        .top_count     (top_count),
        .clock_index   (clock_index)
    );

    // The duty never exceeds the period, before or after prescaling.
    a_cmp_le_top: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> compare_count <= top_count)
        else $error("compare value above counter top");

    // Input backpressure can only come from a stalled, full pipeline.
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output backpressure");

    // A stalled result keeps its payload until it is transferred.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=>
            out_valid && $stable({compare_count, top_count, clock_index}))
        else $error("result changed while stalled");

endmodule

>>> hdl/pwmc_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_front
// Three-stage front end: clamps the frequency, inverts the duty against the
// full scale and rescales it to the counter range.
// ----------------------------------------------------------------------------
module pwmc_front
    import pwmc_pkg::*;
#(
    parameter int COUNTER_BITS = 15
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [DUTY_W-1:0]       duty_value,
    input  logic [FREQ_IN_W-1:0]    freq_hz,
    input  logic [RES_W-1:0]        res_bits,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [COUNTER_BITS-1:0] out_scaled,
    output freq_t                   out_freq
);

    localparam int PROD_W = DUTY_W + COUNTER_BITS;
    localparam logic [COUNTER_BITS-1:0] CMAX = '1;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic en1, en2, en3;

    freq_t               s1_freq_reg, s2_freq_reg, s3_freq_reg;
    logic [DUTY_W-1:0]   s1_w_reg;
    logic                s1_zero_reg, s2_zero_reg;
    logic [RES_W-1:0]    s1_res_reg, s2_res_reg;
    logic [PROD_W-1:0]   s2_prod_reg;
    logic [COUNTER_BITS-1:0] s3_scaled_reg;

    logic [DUTY_W:0]     full;
    logic [DUTY_W:0]     diff;
    freq_t               s1_freq_next;
    logic [DUTY_W-1:0]   s1_w_next;
    logic                s1_zero_next;
    logic [PROD_W-1:0]   s2_prod_next;
    logic [PROD_W-1:0]   shifted;
    logic [COUNTER_BITS-1:0] s3_scaled_next;

    assign en3      = !s3_valid_reg || out_ready;
    assign en2      = !s2_valid_reg || en3;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;

    always_comb
    begin
        if (freq_hz > FREQ_MAX)
            s1_freq_next = FREQ_MAX[FREQ_W-1:0];
        else if (freq_hz < FREQ_MIN)
            s1_freq_next = FREQ_MIN[FREQ_W-1:0];
        else
            s1_freq_next = freq_hz[FREQ_W-1:0];
    end

    // Inverted duty plus one equals full scale minus duty.
    assign full         = (DUTY_W+1)'(1) << res_bits;
    assign diff         = full - {1'b0, duty_value};
    assign s1_w_next    = diff[DUTY_W-1:0];
    assign s1_zero_next = ({1'b0, duty_value} >= full) || (diff == (DUTY_W+1)'(1));

    assign s2_prod_next = PROD_W'(s1_w_reg) * PROD_W'(CMAX);

    assign shifted        = s2_prod_reg >> s2_res_reg;
    assign s3_scaled_next = s2_zero_reg ? '0 : shifted[COUNTER_BITS-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                s1_valid_reg <= in_valid;
            if (en2)
                s2_valid_reg <= s1_valid_reg;
            if (en3)
                s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            s1_freq_reg <= s1_freq_next;
            s1_w_reg    <= s1_w_next;
            s1_zero_reg <= s1_zero_next;
            s1_res_reg  <= res_bits;
        end
        if (en2)
        begin
            s2_freq_reg <= s1_freq_reg;
            s2_prod_reg <= s2_prod_next;
            s2_zero_reg <= s1_zero_reg;
            s2_res_reg  <= s1_res_reg;
        end
        if (en3)
        begin
            s3_freq_reg   <= s2_freq_reg;
            s3_scaled_reg <= s3_scaled_next;
        end
    end

    assign out_valid  = s3_valid_reg;
    assign out_scaled = s3_scaled_reg;
    assign out_freq   = s3_freq_reg;

endmodule

>>> hdl/pwmc_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_div
// Pipelined restoring divider: one quotient bit per stage, computing
// one million divided by the clamped frequency. A sideband rides along.
// ----------------------------------------------------------------------------
module pwmc_div
    import pwmc_pkg::*;
#(
    parameter int SIDE_W = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  freq_t             in_divisor,
    input  logic [SIDE_W-1:0] in_side,
    output logic              out_valid,
    input  logic              out_ready,
    output period_t           out_quot,
    output logic [SIDE_W-1:0] out_side
);

    logic              valid_reg [DIV_W];
    freq_t             dvs_reg   [DIV_W];
    freq_t             rem_reg   [DIV_W];
    logic [DIV_W-1:0]  quo_reg   [DIV_W];
    logic [SIDE_W-1:0] side_reg  [DIV_W];
    logic              en        [DIV_W];

    logic              valid_in  [DIV_W];
    freq_t             dvs_in    [DIV_W];
    freq_t             rem_in    [DIV_W];
    logic [DIV_W-1:0]  quo_in    [DIV_W];
    logic [SIDE_W-1:0] side_in   [DIV_W];

    assign in_ready = en[0];

    for (genvar i = 0; i < DIV_W; i++)
    begin : g_stage
        logic [FREQ_W:0] trial;
        logic [FREQ_W:0] diff;
        logic            geq;
        freq_t           rem_next;
        logic [DIV_W-1:0] quo_next;

        if (i == 0)
        begin : g_first
            assign valid_in[i] = in_valid;
            assign dvs_in[i]   = in_divisor;
            assign rem_in[i]   = '0;
            assign quo_in[i]   = '0;
            assign side_in[i]  = in_side;
        end
        else
        begin : g_next
            assign valid_in[i] = valid_reg[i-1];
            assign dvs_in[i]   = dvs_reg[i-1];
            assign rem_in[i]   = rem_reg[i-1];
            assign quo_in[i]   = quo_reg[i-1];
            assign side_in[i]  = side_reg[i-1];
        end

        if (i == DIV_W - 1)
        begin : g_last_en
            assign en[i] = !valid_reg[i] || out_ready;
        end
        else
        begin : g_mid_en
            assign en[i] = !valid_reg[i] || en[i+1];
        end

        assign trial    = {rem_in[i], US_PER_SECOND[DIV_W-1-i]};
        assign geq      = trial >= {1'b0, dvs_in[i]};
        assign diff     = trial - {1'b0, dvs_in[i]};
        assign rem_next = geq ? diff[FREQ_W-1:0] : trial[FREQ_W-1:0];
        assign quo_next = {quo_in[i][DIV_W-2:0], geq};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                valid_reg[i] <= 1'b0;
            else if (en[i])
                valid_reg[i] <= valid_in[i];
        end

        always_ff @(posedge clk)
        begin
            if (en[i])
            begin
                dvs_reg[i]  <= dvs_in[i];
                rem_reg[i]  <= rem_next;
                quo_reg[i]  <= quo_next;
                side_reg[i] <= side_in[i];
            end
        end

        // The partial remainder always stays below the divisor.
        a_rem_below: assert property (@(posedge clk) disable iff (!rst_n)
            valid_reg[i] |-> rem_reg[i] < dvs_reg[i])
            else $error("divider remainder not below divisor");
    end

    // With the divisor at least four, the quotient never needs the top two bits.
    assign out_valid = valid_reg[DIV_W-1];
    assign out_quot  = quo_reg[DIV_W-1][PERIOD_W-1:0];
    assign out_side  = side_reg[DIV_W-1];

    a_div_range: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |->
            (in_divisor >= FREQ_MIN[FREQ_W-1:0]) && (in_divisor <= FREQ_MAX[FREQ_W-1:0]))
        else $error("divisor outside clamped range");

    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg[DIV_W-1] |-> quo_reg[DIV_W-1][DIV_W-1:PERIOD_W] == '0)
        else $error("quotient overflows period width");

endmodule

>>> hdl/pwmc_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmc_back
// Three-stage back end: converts the duty to microseconds, scales both values
// to clock ticks, picks the prescaler and shifts or saturates the results.
// ----------------------------------------------------------------------------
module pwmc_back
    import pwmc_pkg::*;
#(
    parameter int COUNTER_BITS    = 15,
    parameter int PRESCALER_STEPS = 8
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic [COUNTER_BITS-1:0] in_scaled,
    input  period_t                 in_period,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [CNT_OUT_W-1:0]    compare_count,
    output logic [CNT_OUT_W-1:0]    top_count,
    output logic [IDX_W-1:0]        clock_index
);

    localparam int MUL_W = COUNTER_BITS + 1 + PERIOD_W;
    localparam logic [TICK_W-1:0] CMAX = TICK_W'({COUNTER_BITS{1'b1}});

    logic b1_valid_reg, b2_valid_reg, b3_valid_reg;
    logic en1, en2, en3;

    logic [MUL_W-1:0]     b1_prod_reg;
    logic                 b1_nz_reg;
    period_t              b1_period_reg;
    logic [TICK_W-1:0]    b2_period_t_reg, b2_duty_t_reg;
    logic [IDX_W-1:0]     b2_idx_reg;
    logic                 b2_found_reg;
    logic [CNT_OUT_W-1:0] b3_compare_reg, b3_top_reg;
    logic [IDX_W-1:0]     b3_idx_reg;

    logic [MUL_W-1:0]     b1_prod_next;
    period_t              du;
    period_t              duty_us;
    logic [TICK_W-1:0]    b2_period_t_next, b2_duty_t_next;
    logic [IDX_W-1:0]     b2_idx_next;
    logic                 b2_found_next;
    logic [TICK_W-1:0]    pt_shift, dt_shift, pt_sat, dt_sat;

    assign en3      = !b3_valid_reg || out_ready;
    assign en2      = !b2_valid_reg || en3;
    assign en1      = !b1_valid_reg || en2;
    assign in_ready = en1;

    assign b1_prod_next = MUL_W'(in_scaled) * MUL_W'(in_period) + MUL_W'(in_period);

    // The duty in microseconds never exceeds the period, so it fits the period width.
    assign du = b1_prod_reg[COUNTER_BITS+PERIOD_W-1:COUNTER_BITS];

    always_comb
    begin
        if (!b1_nz_reg)
            duty_us = '0;
        else if (du == '0)
            duty_us = PERIOD_W'(1);
        else
            duty_us = du;
    end

    assign b2_period_t_next = {b1_period_reg, {TICK_SHIFT{1'b0}}};
    assign b2_duty_t_next   = {duty_us, {TICK_SHIFT{1'b0}}};

    // Smallest prescaler shift that brings the period within the counter.
    always_comb
    begin
        b2_idx_next   = IDX_W'(PRESCALER_STEPS - 1);
        b2_found_next = 1'b0;
        for (int k = PRESCALER_STEPS - 1; k >= 0; k--)
        begin
            if ((b2_period_t_next >> k) <= CMAX)
            begin
                b2_idx_next   = IDX_W'(k);
                b2_found_next = 1'b1;
            end
        end
    end

    assign pt_shift = b2_period_t_reg >> b2_idx_reg;
    assign dt_shift = b2_duty_t_reg >> b2_idx_reg;
    assign pt_sat   = (!b2_found_reg && pt_shift > CMAX) ? CMAX : pt_shift;
    assign dt_sat   = (!b2_found_reg && dt_shift > CMAX) ? CMAX : dt_shift;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b1_valid_reg <= 1'b0;
            b2_valid_reg <= 1'b0;
            b3_valid_reg <= 1'b0;
        end
        else
        begin
            if (en1)
                b1_valid_reg <= in_valid;
            if (en2)
                b2_valid_reg <= b1_valid_reg;
            if (en3)
                b3_valid_reg <= b2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            b1_prod_reg   <= b1_prod_next;
            b1_nz_reg     <= (in_scaled != '0);
            b1_period_reg <= in_period;
        end
        if (en2)
        begin
            b2_period_t_reg <= b2_period_t_next;
            b2_duty_t_reg   <= b2_duty_t_next;
            b2_idx_reg      <= b2_idx_next;
            b2_found_reg    <= b2_found_next;
        end
        if (en3)
        begin
            b3_compare_reg <= dt_sat[CNT_OUT_W-1:0];
            b3_top_reg     <= pt_sat[CNT_OUT_W-1:0];
            b3_idx_reg     <= b2_idx_reg;
        end
    end

    assign out_valid     = b3_valid_reg;
    assign compare_count = b3_compare_reg;
    assign top_count     = b3_top_reg;
    assign clock_index   = b3_idx_reg;

endmodule

>>> tb/sv/pwm_period_duty_prescaler_calc_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_period_duty_prescaler_calc_test
// Self-checking bench for the PWM period, duty and prescaler calculator.
// A queue of requests feeds a valid/ready driver. Each accepted request is run
// through a local model of the arithmetic. A monitor compares every result
// transfer with the oldest prediction. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
module pwm_period_duty_prescaler_calc_test
    import pwmc_pkg::*;
();

    localparam int          CNT_BITS     = 15;
    localparam int          PRESC_STEPS  = 8;
    localparam logic [63:0] CNT_LIMIT    = (64'd1 << CNT_BITS) - 64'd1;
    localparam logic [63:0] TICKS_PER_US = 64'd16;
    localparam int          RANDOM_ITEMS = 2000;
    localparam int          CALM_LEVEL   = 120;
    localparam int          TAIL_CYCLES  = 40;

    typedef struct {
        logic [DUTY_W-1:0]    duty;
        logic [FREQ_IN_W-1:0] freq;
        logic [RES_W-1:0]     res;
    } pwm_request_t;

    typedef struct {
        logic [CNT_OUT_W-1:0] compare;
        logic [CNT_OUT_W-1:0] top;
        logic [IDX_W-1:0]     index;
    } pwm_result_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 in_valid = 1'b0;
    logic                 in_ready;
    logic [DUTY_W-1:0]    duty_value = '0;
    logic [FREQ_IN_W-1:0] freq_hz = '0;
    logic [RES_W-1:0]     res_bits = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    logic [CNT_OUT_W-1:0] compare_count;
    logic [CNT_OUT_W-1:0] top_count;
    logic [IDX_W-1:0]     clock_index;

    pwm_request_t request_q[$];
    pwm_result_t  setting_q[$];
    pwm_request_t next_req;
    pwm_result_t  got_setting;
    pwm_result_t  want_setting;

    int  total_items = 0;
    int  accepted_items = 0;
    int  error_count = 0;
    bit  in_took = 1'b0;
    bit  calm = 1'b0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  send_idle_pct = 0;
    int  recv_idle_pct = 0;
    int  cycle_count = 0;

    pwm_period_duty_prescaler_calc dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .duty_value    (duty_value),
        .freq_hz       (freq_hz),
        .res_bits      (res_bits),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .compare_count (compare_count),
        .top_count     (top_count),
        .clock_index   (clock_index)
    );

    always #5 clk = ~clk;

    function automatic pwm_result_t calc_expected(pwm_request_t req);
        logic [63:0]  freq;
        logic [63:0]  full;
        logic [63:0]  inv;
        logic [63:0]  scaled;
        logic [63:0]  period_micro;
        logic [63:0]  duty_us;
        logic [63:0]  period_tk;
        logic [63:0]  duty_tk;
        int           idx;
        bit           found;
        pwm_result_t  result;
        freq = 64'(req.freq);
        if (freq > 64'(FREQ_MAX))
            freq = 64'(FREQ_MAX);
        if (freq < 64'(FREQ_MIN))
            freq = 64'(FREQ_MIN);
        period_micro = 64'(US_PER_SECOND) / freq;

        // Duty is inverted against full scale, then stretched to the counter range.
        full = 64'd1 << req.res;
        if (64'(req.duty) >= full)
        begin
            scaled = '0;
        end
        else
        begin
            inv = full - 64'd1 - 64'(req.duty);
            scaled = (inv == 0) ? 64'd0 : (((inv + 64'd1) * CNT_LIMIT) >> req.res);
        end

        if (scaled != 0)
        begin
            duty_us = ((scaled + 64'd1) * period_micro) >> CNT_BITS;
            if (duty_us == 0)
                duty_us = 64'd1;
        end
        else
        begin
            duty_us = '0;
        end

        period_tk = period_micro * TICKS_PER_US;
        duty_tk = duty_us * TICKS_PER_US;
        found = 1'b0;
        for (idx = 0; idx < PRESC_STEPS; idx++)
        begin
            if (period_tk <= CNT_LIMIT)
            begin
                found = 1'b1;
                break;
            end
            if (idx + 1 < PRESC_STEPS)
            begin
                period_tk = period_tk >> 1;
                duty_tk = duty_tk >> 1;
            end
        end
        if (!found)
        begin
            idx = PRESC_STEPS - 1;
            if (period_tk > CNT_LIMIT)
                period_tk = CNT_LIMIT;
            if (duty_tk > CNT_LIMIT)
                duty_tk = CNT_LIMIT;
        end

        result.compare = duty_tk[CNT_OUT_W-1:0];
        result.top = period_tk[CNT_OUT_W-1:0];
        result.index = idx[IDX_W-1:0];
        return result;
    endfunction

    function automatic void add_request(int duty, int freq, int res);
        pwm_request_t req;
        req.duty = duty[DUTY_W-1:0];
        req.freq = freq[FREQ_IN_W-1:0];
        req.res = res[RES_W-1:0];
        request_q.push_back(req);
        total_items++;
    endfunction

    function automatic void add_random_request();
        int res;
        int full;
        int duty;
        int freq;
        int pick;
        res = $urandom_range(0, 15);
        full = 1 << res;
        pick = $urandom_range(0, 99);
        if (pick < 55)
            duty = $urandom_range(0, full);
        else if (pick < 75)
            duty = (pick % 3 == 0) ? 0 : ((pick % 3 == 1) ? full - 1 : full);
        else
            duty = $urandom_range(0, 65535);
        pick = $urandom_range(0, 99);
        if (pick < 40)
            freq = $urandom_range(4, 500000);
        else if (pick < 60)
            freq = $urandom_range(0, 100);
        else if (pick < 80)
            freq = $urandom_range(0, 1048575);
        else
            freq = $urandom_range(400000, 1048575);
        add_request(duty, freq, res);
    endfunction

    task automatic note_failure(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        error_count++;
    endtask

    // Acceptance and result checking, both sampled at the rising edge.
    always @(posedge clk)
    begin
        in_took <= in_valid && in_ready;
        if (rst_n && in_valid && in_ready)
        begin
            next_req.duty = duty_value;
            next_req.freq = freq_hz;
            next_req.res = res_bits;
            setting_q.push_back(calc_expected(next_req));
            accepted_items++;
        end
        if (rst_n && out_valid && out_ready)
        begin
            got_setting.compare = compare_count;
            got_setting.top = top_count;
            got_setting.index = clock_index;
            if (setting_q.size() == 0)
            begin
                note_failure($sformatf("result with nothing pending (cmp %0d top %0d idx %0d)",
                                       compare_count, top_count, clock_index));
            end
            else
            begin
                want_setting = setting_q.pop_front();
                if (got_setting.compare !== want_setting.compare)
                    note_failure($sformatf("compare_count %0d, want %0d",
                                           got_setting.compare, want_setting.compare));
                if (got_setting.top !== want_setting.top)
                    note_failure($sformatf("top_count %0d, want %0d",
                                           got_setting.top, want_setting.top));
                if (got_setting.index !== want_setting.index)
                    note_failure($sformatf("clock_index %0d, want %0d",
                                           got_setting.index, want_setting.index));
            end
        end
    end

    // Request driver and result backpressure, both changing at the falling edge.
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            cycle_count <= cycle_count + 1;
            if (cycle_count % 100 == 0)
            begin
                send_idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
                recv_idle_pct <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(2, 30);
            end
            if (request_q.size() < CALM_LEVEL)
                calm <= 1'b1;

            if (!in_valid || in_took)
            begin
                if (send_gap > 0)
                begin
                    in_valid <= 1'b0;
                    send_gap <= send_gap - 1;
                end
                else if (!calm && $urandom_range(0, 99) < send_idle_pct)
                begin
                    in_valid <= 1'b0;
                    send_gap <= $urandom_range(0, 16);
                end
                else if (request_q.size() > 0)
                begin
                    next_req = request_q.pop_front();
                    in_valid <= 1'b1;
                    duty_value <= next_req.duty;
                    freq_hz <= next_req.freq;
                    res_bits <= next_req.res;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end

            if (recv_gap > 0)
            begin
                out_ready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end
            else if (!calm && $urandom_range(0, 99) < recv_idle_pct)
            begin
                out_ready <= 1'b0;
                recv_gap <= $urandom_range(0, 16);
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    initial
    begin
        // Directed corners: clamping, full-scale duty, zero inverted duty,
        // the one-microsecond floor and the widest duty product.
        add_request(0, 1000, 15);
        add_request(32767, 1000, 15);
        add_request(32768, 1000, 15);
        add_request(65535, 1000, 15);
        add_request(0, 0, 1);
        add_request(1, 0, 1);
        add_request(2, 3, 1);
        add_request(0, 4, 8);
        add_request(255, 5, 8);
        add_request(256, 500000, 8);
        add_request(0, 500001, 8);
        add_request(100, 1048575, 12);
        add_request(0, 1048575, 0);
        add_request(1, 250, 0);
        add_request(65535, 0, 15);
        add_request(16383, 1, 14);
        add_request(1, 499999, 15);
        add_request(0, 15625, 4);
        add_request(7, 31, 3);
        add_request(32766, 1000000, 15);
        add_request(0, 4, 15);
        add_request(32766, 500000, 15);
        add_request(43690, 699050, 10);
        add_request(21845, 349525, 5);
        for (int i = 0; i < RANDOM_ITEMS; i++)
            add_random_request();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_items < total_items)
            @(posedge clk);
        while (setting_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("timeout at %0t", $realtime);
        $display("CHECK FAILED");
        $finish;
    end

endmodule

>>> filelist.f
hdl/pwmc_pkg.sv
hdl/pwmc_front.sv
hdl/pwmc_div.sv
hdl/pwmc_back.sv
hdl/pwm_period_duty_prescaler_calc.sv
tb/sv/pwm_period_duty_prescaler_calc_test.sv
